// ----- rtl/uwf_pkg.sv -----
// shared types and constants for the unique word filter
`timescale 1ns / 1ps
package uwf_pkg;
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] CHAR_PERIOD = 8'h2e;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMP_LEN,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_STORE,
        ST_EMIT,
        ST_TAIL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_RUNNING,
        MODE_ENDED,
        MODE_ERROR
    } mode_t;

    typedef struct packed {
        logic load_char;
        logic clear_word;
        logic clear_cmp;
        logic next_word;
        logic next_char;
        logic clear_char;
        logic store_char;
        logic store_len;
        logic inc_count;
        logic emit;
        logic emit_tail;
    } cmd_t;

    typedef struct packed {
        logic       is_letter;
        logic       is_blank;
        logic       is_period;
        logic       word_empty;
        logic       words_done;
        logic       len_match;
        logic       char_match;
        logic       chars_done;
        logic       store_full;
        logic       out_busy;
    } status_t;

    function automatic logic letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic logic blank(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction
endpackage

// ----- rtl/uwf_stream_if.sv -----
// valid/ready channel
`timescale 1ns / 1ps
interface uwf_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/uwf_out_if.sv -----
// result channel
`timescale 1ns / 1ps
interface uwf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [1:0] kind;
    logic       last_of_run;
    logic       not_remembered;
    modport source (output valid, output out_char, output kind, output last_of_run,
                    output not_remembered, input ready);
    modport sink (input valid, input out_char, input kind, input last_of_run,
                  input not_remembered, output ready);
endinterface

// ----- rtl/uwf_ctrl.sv -----
// controller for the unique word filter
`timescale 1ns / 1ps
module uwf_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  uwf_pkg::status_t st,
    output uwf_pkg::cmd_t    cmd,
    output logic             tail_kind_end
);
    uwf_pkg::state_t state_reg, state_next;
    uwf_pkg::mode_t  mode_reg, mode_next;
    logic            period_reg, period_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= uwf_pkg::ST_IDLE;
            mode_reg   <= uwf_pkg::MODE_RUNNING;
            period_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            period_reg <= period_next;
        end
    end

    assign tail_kind_end = period_reg;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        period_next = period_reg;
        case (state_reg)
            uwf_pkg::ST_IDLE:
            begin
                if (in_valid && mode_reg == uwf_pkg::MODE_RUNNING)
                begin
                    if (st.is_letter)
                        state_next = uwf_pkg::ST_IDLE;
                    else if (st.is_blank || st.is_period)
                    begin
                        period_next = st.is_period;
                        if (st.is_period)
                            mode_next = uwf_pkg::MODE_ENDED;
                        state_next = st.word_empty ?
                            (st.is_period ? uwf_pkg::ST_TAIL : uwf_pkg::ST_IDLE)
                            : uwf_pkg::ST_CMP_LEN;
                    end
                    else
                    begin
                        period_next = 1'b0;
                        mode_next   = uwf_pkg::MODE_ERROR;
                        state_next  = uwf_pkg::ST_TAIL;
                    end
                end
            end
            uwf_pkg::ST_CMP_LEN:
            begin
                if (st.words_done)
                    state_next = uwf_pkg::ST_STORE;
                else if (st.len_match)
                    state_next = uwf_pkg::ST_CMP_RD;
            end
            uwf_pkg::ST_CMP_RD: state_next = uwf_pkg::ST_CMP_CHK;
            uwf_pkg::ST_CMP_CHK:
            begin
                if (!st.char_match)
                    state_next = uwf_pkg::ST_CMP_LEN;
                else if (st.chars_done)
                    state_next = period_reg ? uwf_pkg::ST_TAIL : uwf_pkg::ST_IDLE;
                else
                    state_next = uwf_pkg::ST_CMP_RD;
            end
            uwf_pkg::ST_STORE:
            begin
                if (st.store_full || st.chars_done)
                    state_next = uwf_pkg::ST_EMIT;
            end
            uwf_pkg::ST_EMIT:
            begin
                if (!st.out_busy && st.chars_done)
                    state_next = period_reg ? uwf_pkg::ST_TAIL : uwf_pkg::ST_IDLE;
            end
            uwf_pkg::ST_TAIL:
            begin
                if (!st.out_busy)
                    state_next = uwf_pkg::ST_IDLE;
            end
            default: state_next = uwf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = (state_reg == uwf_pkg::ST_IDLE);
        case (state_reg)
            uwf_pkg::ST_IDLE:
            begin
                if (in_valid && mode_reg == uwf_pkg::MODE_RUNNING)
                begin
                    cmd.load_char  = st.is_letter;
                    cmd.clear_word = !st.is_letter && !st.is_blank && !st.is_period;
                    cmd.clear_cmp  = 1'b1;
                end
            end
            uwf_pkg::ST_CMP_LEN:
            begin
                cmd.clear_char = 1'b1;
                if (!st.words_done && !st.len_match)
                    cmd.next_word = 1'b1;
            end
            uwf_pkg::ST_CMP_CHK:
            begin
                if (!st.char_match)
                    cmd.next_word = 1'b1;
                else if (st.chars_done)
                    cmd.clear_word = 1'b1;
                else
                    cmd.next_char = 1'b1;
            end
            uwf_pkg::ST_STORE:
            begin
                if (st.store_full)
                    cmd.clear_char = 1'b1;
                else
                begin
                    cmd.store_char = 1'b1;
                    if (st.chars_done)
                    begin
                        cmd.clear_char = 1'b1;
                        cmd.store_len  = 1'b1;
                        cmd.inc_count  = 1'b1;
                    end
                    else
                        cmd.next_char = 1'b1;
                end
            end
            uwf_pkg::ST_EMIT:
            begin
                if (!st.out_busy)
                begin
                    cmd.emit      = 1'b1;
                    cmd.next_char = 1'b1;
                    if (st.chars_done)
                        cmd.clear_word = 1'b1;
                end
            end
            uwf_pkg::ST_TAIL:
            begin
                if (!st.out_busy)
                    cmd.emit_tail = 1'b1;
            end
            default: cmd = '0;
        endcase
    end
endmodule

// ----- rtl/uwf_datapath.sv -----
// word buffer, word store and output register
`timescale 1ns / 1ps
module uwf_datapath #(
    parameter int MAX_WORD_LEN = 31,
    parameter int MAX_WORDS    = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_char,
    input  uwf_pkg::cmd_t    cmd,
    input  logic             tail_kind_end,
    output uwf_pkg::status_t st,
    uwf_out_if.source        out
);
    localparam int LW = $clog2(MAX_WORD_LEN + 1);
    localparam int CW = $clog2(MAX_WORDS + 1);
    localparam int WI = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int KI = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int AW = $clog2(MAX_WORDS * MAX_WORD_LEN);
    localparam int DEPTH = MAX_WORDS * MAX_WORD_LEN;

    logic [7:0]    cur_mem [MAX_WORD_LEN];
    logic [7:0]    store_mem [DEPTH];
    logic [LW-1:0] len_mem [MAX_WORDS];

    logic [LW-1:0] cur_len_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] widx_reg;
    logic [LW-1:0] cidx_reg;
    logic [AW-1:0] base_reg;
    logic [7:0]    sdata_reg;
    logic [LW-1:0] slen_reg;
    logic          word_nr_reg;

    logic          ovalid_reg;
    logic [7:0]    ochar_reg;
    logic [1:0]    okind_reg;
    logic          olast_reg;
    logic          onr_reg;

    logic [AW-1:0] wr_base;
    logic [7:0]    cur_at;
    logic          full;
    logic [CW-1:0] widx_rd;

    assign full    = (count_reg == CW'(MAX_WORDS));
    assign wr_base = AW'(count_reg * MAX_WORD_LEN);
    assign cur_at  = cur_mem[cidx_reg[KI-1:0]];

    // length read follows the word index it is about to take
    assign widx_rd = cmd.clear_cmp ? '0 : (cmd.next_word ? widx_reg + CW'(1) : widx_reg);

    assign st.is_letter  = uwf_pkg::letter(in_char);
    assign st.is_blank   = uwf_pkg::blank(in_char);
    assign st.is_period  = (in_char == uwf_pkg::CHAR_PERIOD);
    assign st.word_empty = (cur_len_reg == '0);
    assign st.words_done = (widx_reg >= count_reg);
    assign st.len_match  = (slen_reg == cur_len_reg);
    assign st.char_match = (sdata_reg == cur_at);
    assign st.chars_done = ({1'b0, cidx_reg} + (LW+1)'(1)) >= {1'b0, cur_len_reg};
    assign st.store_full = full;
    assign st.out_busy   = ovalid_reg && !out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_len_reg <= '0;
            count_reg   <= '0;
            widx_reg    <= '0;
            cidx_reg    <= '0;
            base_reg    <= '0;
            word_nr_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_char && cur_len_reg < LW'(MAX_WORD_LEN))
                cur_len_reg <= cur_len_reg + LW'(1);
            if (cmd.clear_word)
                cur_len_reg <= '0;
            if (cmd.clear_cmp)
            begin
                widx_reg    <= '0;
                base_reg    <= '0;
                // a word that ends with the store already full is not stored
                word_nr_reg <= full;
            end
            if (cmd.next_word)
            begin
                widx_reg <= widx_reg + CW'(1);
                base_reg <= base_reg + AW'(MAX_WORD_LEN);
            end
            if (cmd.clear_char || cmd.next_word)
                cidx_reg <= '0;
            else if (cmd.next_char)
                cidx_reg <= cidx_reg + LW'(1);
            if (cmd.inc_count)
                count_reg <= count_reg + CW'(1);
            if (cmd.emit || cmd.emit_tail)
                ovalid_reg <= 1'b1;
            else if (out.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // stores and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_char && cur_len_reg < LW'(MAX_WORD_LEN))
            cur_mem[cur_len_reg[KI-1:0]] <= in_char;
        if (cmd.store_char)
            store_mem[wr_base + AW'(cidx_reg)] <= cur_at;
        if (cmd.store_len)
            len_mem[count_reg[WI-1:0]] <= cur_len_reg;
        sdata_reg <= store_mem[base_reg + AW'(cidx_reg)];
        slen_reg  <= len_mem[widx_rd[WI-1:0]];
        if (cmd.emit)
        begin
            ochar_reg <= cur_at;
            okind_reg <= uwf_pkg::KIND_CHAR;
            olast_reg <= st.chars_done && !tail_kind_end;
            onr_reg   <= word_nr_reg;
        end
        if (cmd.emit_tail)
        begin
            ochar_reg <= tail_kind_end ? 8'd0 : in_char;
            okind_reg <= tail_kind_end ? uwf_pkg::KIND_END : uwf_pkg::KIND_ERROR;
            olast_reg <= 1'b1;
            onr_reg   <= 1'b0;
        end
    end

    assign out.valid          = ovalid_reg;
    assign out.out_char       = ochar_reg;
    assign out.kind           = okind_reg;
    assign out.last_of_run    = olast_reg;
    assign out.not_remembered = onr_reg;
endmodule

// ----- rtl/unique_word_filter.sv -----
// unique word filter top level
// Channels: in (valid/ready, data) and out (valid/ready, result fields).
// A letter byte is accepted while idle and gives no result. A blank or period
// that ends a word walks the stored words one at a time, comparing characters
// one at a time where the length is equal; a new word is then copied into the
// word store character by character (not at all when the store is full) and
// emitted one character per result. No new byte is taken until this is done.
// The word store has a read and a write port; it is read at one address per
// cycle. A period adds one end result, any other byte one error result;
// after either the block drops all input.
// Results sit in one output register; while the receiver stalls the result
// holds, letters are still taken, and a word end or end/error result waits
// until the register frees.
// Reset clears the word count, word length and run mode at once; there is
// no clearing pass, since only stored entries are ever used.
// The offending byte of an error is captured into a register at the
// accepting edge, so in.data need not be held afterwards.
`timescale 1ns / 1ps
module unique_word_filter #(
    parameter int MAX_WORD_LEN = 31,
    parameter int MAX_WORDS    = 64
)
(
    input logic        clk,
    input logic        rst_n,
    uwf_stream_if.sink in,
    uwf_out_if.source  out
);
    uwf_pkg::cmd_t    cmd;
    uwf_pkg::status_t st;
    logic             tail_end;
    logic [7:0]       char_reg;
    logic [7:0]       char_sel;
    logic             in_ready;

    assign in.ready = in_ready;

    always_ff @(posedge clk)
    begin
        if (in.valid && in_ready)
            char_reg <= in.data;
    end

    // live byte while idle, captured byte for the error result
    assign char_sel = in_ready ? in.data : char_reg;

    uwf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in.valid),
        .in_ready      (in_ready),
        .st            (st),
        .cmd           (cmd),
        .tail_kind_end (tail_end)
    );

    uwf_datapath #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .MAX_WORDS    (MAX_WORDS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_char       (char_sel),
        .cmd           (cmd),
        .tail_kind_end (tail_end),
        .st            (st),
        .out           (out)
    );
endmodule

// ----- rtl/uwf_checker.sv -----
// port checker for the unique word filter
`timescale 1ns / 1ps
module uwf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic [1:0] kind,
    input logic       last_of_run
);
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == uwf_pkg::KIND_CHAR || kind == uwf_pkg::KIND_END
                       || kind == uwf_pkg::KIND_ERROR))
        else $error("bad result kind");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char))
        else $error("stalled result changed");
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == uwf_pkg::KIND_END |-> out_char == 8'd0)
        else $error("end result with data");
    a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != uwf_pkg::KIND_CHAR |-> last_of_run)
        else $error("end or error result not last");
endmodule

bind unique_word_filter uwf_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out.valid),
    .out_ready   (out.ready),
    .out_char    (out.out_char),
    .kind        (out.kind),
    .last_of_run (out.last_of_run)
);

// ----- test/unique_word_filter_test.sv -----
// unique word filter testbench: directed, store-fill, random, end texts; checked per result
`timescale 1ns / 1ps
module unique_word_filter_test;
    localparam int WORD_MAX  = 31;
    localparam int STORE_MAX = 64;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] kind;
        logic       last_of_run;
        logic       not_remembered;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   calm = 1'b0;
    int   mismatches = 0;
    bit   failed = 1'b0;

    uwf_stream_if #(.W(8)) in_ch();
    uwf_out_if out_ch();

    unique_word_filter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source)
    );

    always #10 clk = ~clk;

    // predictor state
    logic [7:0]      pending_word[WORD_MAX];
    int              pending_len;
    string           known_words[$];
    uwf_pkg::mode_t  text_mode;
    result_t         expected_results[$];

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == uwf_pkg::CHAR_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void push_result(logic [7:0] ch, logic [1:0] k, logic nr);
        result_t r;
        r.out_char = ch;
        r.kind = k;
        r.last_of_run = 1'b0;
        r.not_remembered = nr;
        expected_results.push_back(r);
    endfunction

    function automatic void close_word();
        string w;
        bit    seen;
        logic  nr;
        w = "";
        seen = 1'b0;
        if (pending_len == 0)
            return;
        for (int k = 0; k < pending_len; k++)
            w = {w, string'(pending_word[k])};
        foreach (known_words[i])
            if (known_words[i] == w)
                seen = 1'b1;
        if (!seen) begin
            nr = known_words.size() >= STORE_MAX;
            if (!nr)
                known_words.push_back(w);
            for (int k = 0; k < pending_len; k++)
                push_result(pending_word[k], uwf_pkg::KIND_CHAR, nr);
        end
        pending_len = 0;
    endfunction

    function automatic void predict_byte(logic [7:0] c);
        int before_n;
        before_n = expected_results.size();
        if (text_mode != uwf_pkg::MODE_RUNNING)
            return;
        if (is_alpha(c)) begin
            if (pending_len < WORD_MAX)
            begin
                pending_word[pending_len] = c;
                pending_len++;
            end
            return;
        end
        if (is_space(c))
            close_word();
        else if (c == uwf_pkg::CHAR_PERIOD) begin
            close_word();
            push_result(8'd0, uwf_pkg::KIND_END, 1'b0);
            text_mode = uwf_pkg::MODE_ENDED;
        end else begin
            pending_len = 0;
            push_result(c, uwf_pkg::KIND_ERROR, 1'b0);
            text_mode = uwf_pkg::MODE_ERROR;
        end
        if (expected_results.size() > before_n)
            expected_results[$].last_of_run = 1'b1;
    endfunction

    // send one byte, with random idle cycles before it unless calm is set
    task automatic send_byte(logic [7:0] c);
        while (!calm && $urandom_range(99) < 24) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= c;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_byte(c);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // the block keeps its store until reset, and reset is given once only,
    // so after a period or error everything else is ignored input
    task automatic wait_drained();
        int guard;
        guard = 0;
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n)
            out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
    end

    always @(posedge clk) begin
        result_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.out_char = out_ch.out_char;
            got.kind = out_ch.kind;
            got.last_of_run = out_ch.last_of_run;
            got.not_remembered = out_ch.not_remembered;
            if (expected_results.size() == 0) begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    function automatic logic [7:0] rand_letter();
        logic [7:0] b;
        b = 8'($urandom_range(25));
        return $urandom_range(1) ? "a" + b : "A" + b;
    endfunction

    function automatic logic [7:0] rand_space();
        return $urandom_range(3) == 0 ? 8'(8'd9 + $urandom_range(4)) : uwf_pkg::CHAR_SPACE;
    endfunction

    task automatic test_directed();
        send_text("Zebra zebra  Zebra\tab\nab\v");
        send_byte(8'd12);
        send_byte(8'd13);
        // overlong word, then the same word cut
        send_text({"abcdefghijklmnopqrstuvwxyzABCDEFGH ", "abcdefghijklmnopqrstuvwxyzABCDE "});
        send_text("z Az ");
    endtask

    // distinct short words until the store is past full
    task automatic test_fill_store();
        logic [7:0] b;
        for (int i = 0; i < 52; i++) begin
            b = (i < 26) ? 8'(8'h61 + i) : 8'(8'h41 + i - 26);
            send_byte(b);
            send_byte(uwf_pkg::CHAR_SPACE);
        end
        for (int i = 0; i < 12; i++) begin
            b = 8'(8'h61 + i);
            send_text({"Qx", string'(b)});
            send_byte(uwf_pkg::CHAR_SPACE);
        end
    endtask

    // random words, some repeated, with the store already full
    task automatic test_random_words();
        string vocab[$];
        string w;
        int    n, len;
        for (int i = 0; i < 90; i++) begin
            w = "";
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 25) : $urandom_range(5, 1);
            for (int k = 0; k < len; k++)
                w = {w, string'(rand_letter())};
            vocab.push_back(w);
        end
        n = 0;
        while (n < 50) begin
            if ($urandom_range(2) == 0 && n > 0)
                w = vocab[$urandom_range(vocab.size() - 1)];
            else
                w = vocab[$urandom_range(vocab.size() - 1) % (n / 3 + 1)];
            send_text(w);
            send_byte(rand_space());
            if ($urandom_range(6) == 0)
                send_byte(rand_space());
            n += w.len() + 1;
        end
    endtask

    task automatic test_terminator();
        // a stored word repeated, a new word, then the period
        send_text("Zebra final");
        send_byte(uwf_pkg::CHAR_PERIOD);
        // ignored after the end
        send_text("ignored 12 words");
        send_byte(8'hff);
        send_byte(8'h00);
    endtask

    initial begin
        text_mode = uwf_pkg::MODE_RUNNING;
        pending_len = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        calm = 1'b1;
        test_fill_store();
        calm = 1'b0;
        test_random_words();
        test_terminator();
        wait_drained();
        if (!failed && expected_results.size() == 0)
            $display("unique_word_filter_test OK");
        else
            $display("unique_word_filter_test NOT OK");
        $finish;
    end

    initial begin
        #50ms;
        $display("unique_word_filter_test NOT OK");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/uwf_pkg.sv
rtl/uwf_stream_if.sv
rtl/uwf_out_if.sv
rtl/uwf_ctrl.sv
rtl/uwf_datapath.sv
rtl/unique_word_filter.sv
rtl/uwf_checker.sv
test/unique_word_filter_test.sv
